// ===== rtl/srds_pkg.sv =====
package srds_pkg;

   localparam int RANGE_BITS_DEF = 16;
   localparam int RANGE_W        = 16;
   localparam int DITHER_W       = 17;
   localparam int SEED_W         = 32;
   localparam int MAG_W          = 52;
   localparam int CHUNK_W        = 26;
   localparam int FRAC_W         = 51;
   localparam int CSR_IDX_W      = 2;
   localparam int TDATA_IN_W     = 16;
   localparam int TDATA_OUT_W    = 56;

   localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
   localparam logic [SEED_W-1:0] LCG_INC = 32'd1013904223;
   localparam logic [MAG_W-1:0]  HALF_SCALE = 52'd1 << FRAC_W;

   localparam logic MODE_XOR = 1'b0;
   localparam logic MODE_LCG = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEED = 2'd1;

   // one step of the datapath per flag
   typedef struct packed {
      logic capture;
      logic gen;
      logic mag;
      logic mul_lo;
      logic mul_hi;
      logic acc;
      logic out_load;
   } cmd_type;

endpackage

// ===== rtl/srds_ctrl.sv =====
module srds_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output srds_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GEN,
      ST_MAG,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACC,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      valid_in   = valid_ff;
      req_tready = (state_ff == ST_IDLE);
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_GEN;
            end
         end
         ST_GEN: begin
            cmd.gen  = 1'b1;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            cmd.mag  = 1'b1;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait until the output register is free or being drained
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

// ===== rtl/srds_datapath.sv =====
module srds_datapath #(
   parameter int RANGE_BITS = srds_pkg::RANGE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [srds_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [srds_pkg::SEED_W-1:0]            csr_wr_data,
   input  logic [srds_pkg::RANGE_W-1:0]           req_range,
   input  srds_pkg::cmd_type                      cmd,
   output logic signed [srds_pkg::DITHER_W-1:0]   rsp_dither,
   output logic [srds_pkg::SEED_W-1:0]            rsp_seed
);

   localparam int RW = (RANGE_BITS < srds_pkg::RANGE_W) ? RANGE_BITS : srds_pkg::RANGE_W;
   localparam int PW = srds_pkg::CHUNK_W + RW;
   localparam int AW = srds_pkg::MAG_W + RW;
   localparam int QW = AW - srds_pkg::FRAC_W;

   logic                                 mode_ff;
   logic [srds_pkg::SEED_W-1:0]          seed_ff, seed_in;
   logic [RW-1:0]                        r_ff;
   logic [srds_pkg::MAG_W-1:0]           mag_ff, mag_in;
   logic [PW-1:0]                        prod_ff, prod_in;
   logic [AW-1:0]                        acc_ff;
   logic signed [srds_pkg::DITHER_W-1:0] dither_ff, dither_in;
   logic [srds_pkg::SEED_W-1:0]          out_seed_ff;

   logic [srds_pkg::SEED_W-1:0]  sh, t, xor_next, lcg_next;
   logic [srds_pkg::MAG_W-1:0]   m_val;
   logic [srds_pkg::CHUNK_W-1:0] mul_a;
   logic [QW-1:0]                q_val;
   logic [srds_pkg::DITHER_W-1:0] q_mag;

   always_comb begin
      sh       = seed_ff << 13;
      t        = ((sh ^ seed_ff) >> 17) ^ sh ^ seed_ff;
      xor_next = (t << 5) ^ t;
      lcg_next = seed_ff * srds_pkg::LCG_MUL + srds_pkg::LCG_INC;
      seed_in  = (mode_ff == srds_pkg::MODE_LCG) ? lcg_next : xor_next;

      // spread the seed to 52 bits and take the distance from the midpoint
      m_val  = {seed_ff, seed_ff[srds_pkg::SEED_W-1:12]};
      mag_in = seed_ff[srds_pkg::SEED_W-1] ? (m_val - srds_pkg::HALF_SCALE)
                                            : (srds_pkg::HALF_SCALE - m_val);

      mul_a   = cmd.mul_hi ? mag_ff[srds_pkg::MAG_W-1:srds_pkg::CHUNK_W]
                           : mag_ff[srds_pkg::CHUNK_W-1:0];
      prod_in = PW'(mul_a) * PW'(r_ff);

      q_val     = acc_ff[AW-1:srds_pkg::FRAC_W] + QW'(acc_ff[srds_pkg::FRAC_W-1]);
      q_mag     = srds_pkg::DITHER_W'(q_val);
      dither_in = seed_ff[srds_pkg::SEED_W-1] ? signed'(q_mag) : -signed'(q_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= srds_pkg::MODE_LCG;
         seed_ff <= '0;
      end else if (csr_wr_en && csr_index == srds_pkg::REG_MODE) begin
         mode_ff <= csr_wr_data[0];
      end else if (csr_wr_en && csr_index == srds_pkg::REG_SEED) begin
         seed_ff <= csr_wr_data;
      end else if (cmd.gen) begin
         seed_ff <= seed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         r_ff <= req_range[RW-1:0];
      end
      if (cmd.mag) begin
         mag_ff <= mag_in;
      end
      if (cmd.mul_lo || cmd.mul_hi) begin
         prod_ff <= prod_in;
      end
      if (cmd.mul_hi) begin
         acc_ff <= AW'(prod_ff);
      end else if (cmd.acc) begin
         acc_ff <= acc_ff + {prod_ff, srds_pkg::CHUNK_W'(0)};
      end
      if (cmd.out_load) begin
         dither_ff   <= dither_in;
         out_seed_ff <= seed_ff;
      end
   end

   assign rsp_dither = dither_ff;
   assign rsp_seed   = out_seed_ff;

endmodule

// ===== rtl/scaled_random_dither_source.sv =====
// Scaled random dither source. Each request transaction advances a 32-bit
// seed (shift-xor or linear congruential, chosen by register 0) and returns
// one signed value, the seed scaled to [-range, range] and rounded half away
// from zero, together with the new seed. One item is in work at a time: after
// acceptance the block runs the seed step, the magnitude step and two passes
// through a shared 26 x 16 multiplier with an accumulate, then loads the
// result once the output register is free. A finished result waits in the
// output register, so the next request is taken while it
// is pending. Writing the seed register (index 1) also reloads the running
// seed; write registers only while the block is idle.
module scaled_random_dither_source #(
   parameter int RANGE_BITS = srds_pkg::RANGE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [15:0] scale_range
   input  logic [srds_pkg::TDATA_IN_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [16:0] dither_value, [48:17] new_seed, [55:49] zero
   output logic [srds_pkg::TDATA_OUT_W-1:0]     rsp_tdata,
   input  logic                                 csr_wr_en,
   input  logic [srds_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [srds_pkg::SEED_W-1:0]          csr_wr_data
);

   srds_pkg::cmd_type                    cmd;
   logic signed [srds_pkg::DITHER_W-1:0] dither;
   logic [srds_pkg::SEED_W-1:0]          new_seed;

   srds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   srds_datapath #(
      .RANGE_BITS (RANGE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_range   (req_tdata[srds_pkg::RANGE_W-1:0]),
      .cmd         (cmd),
      .rsp_dither  (dither),
      .rsp_seed    (new_seed)
   );

   assign rsp_tdata = {
      (srds_pkg::TDATA_OUT_W - srds_pkg::DITHER_W - srds_pkg::SEED_W)'(0),
      new_seed, dither};

   // no new transaction while one is in work
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while busy");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.out_load))
      else $error("result valid without a load");

   // negative values only come from seeds below the midpoint
   a_sign_matches_seed: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && dither[srds_pkg::DITHER_W-1]) |-> !new_seed[srds_pkg::SEED_W-1])
      else $error("dither sign does not match seed");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && rsp_tvalid) |-> rsp_tready)
      else $error("pending result overwritten");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int LIMIT_CYCLES   = 400000;
   localparam int HOLD_CYCLES    = 250;
   localparam int ITEMS_PER_PASS = 122;
   localparam int N_PASSES       = 4;
   localparam int N_DIRECTED     = 24;

   // indexes with no register behind them
   localparam logic [srds_pkg::CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [srds_pkg::CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   typedef struct {
      row_kind_type                   kind;
      logic [srds_pkg::CSR_IDX_W-1:0] index;
      logic [srds_pkg::SEED_W-1:0]    value;
      logic [srds_pkg::RANGE_W-1:0]   range;
      bit                             fixed;
      logic [srds_pkg::DITHER_W-1:0]  dither;
      logic [srds_pkg::SEED_W-1:0]    seed;
   } stim_row_type;

   typedef struct {
      logic [srds_pkg::DITHER_W-1:0] dither;
      logic [srds_pkg::SEED_W-1:0]   seed;
   } dither_result_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [srds_pkg::TDATA_IN_W-1:0]    req_tdata = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [srds_pkg::TDATA_OUT_W-1:0]   rsp_tdata;
   logic                               csr_wr_en = 1'b0;
   logic [srds_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [srds_pkg::SEED_W-1:0]        csr_wr_data = '0;

   dither_result_type pending_dither [$];
   logic           model_mode;
   logic [31:0]    model_seed;
   int             src_idle_pct  = 0;
   int             sink_stall_pct = 0;
   bit             hold_go = 1'b0;
   bit             hold_done = 1'b0;
   int             hold_left = 0;
   int             mismatch_count = 0;
   int             cycle_count = 0;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'h0000, 1'b1, 17'h00000, 32'h3C6EF35F},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'hFFFF, 1'b0, 17'h0,     32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'h0001, 1'b0, 17'h0,     32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'h8000, 1'b0, 17'h0,     32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'h5555, 1'b0, 17'h0,     32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'hAAAA, 1'b0, 17'h0,     32'h0},
      '{ROW_CSR, srds_pkg::REG_MODE, 32'hFFFFFFFE, 16'h0,    1'b0, 17'h0,     32'h0},
      '{ROW_CSR, srds_pkg::REG_SEED, 32'h00000000, 16'h0,    1'b0, 17'h0,     32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'hFFFF, 1'b1, 17'h10001, 32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'h0001, 1'b1, 17'h1FFFF, 32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'h0000, 1'b1, 17'h00000, 32'h0},
      '{ROW_CSR, REG_SPARE_2,        32'hFFFFFFFF, 16'h0,    1'b0, 17'h0,     32'h0},
      '{ROW_CSR, REG_SPARE_3,        32'h12345678, 16'h0,    1'b0, 17'h0,     32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'h00FF, 1'b1, 17'h1FF01, 32'h0},
      '{ROW_CSR, srds_pkg::REG_SEED, 32'hFFFFFFFF, 16'h0,    1'b0, 17'h0,     32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'hFFFF, 1'b0, 17'h0,     32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'hFF00, 1'b0, 17'h0,     32'h0},
      '{ROW_CSR, srds_pkg::REG_MODE, 32'h00000001, 16'h0,    1'b0, 17'h0,     32'h0},
      '{ROW_CSR, srds_pkg::REG_SEED, 32'h80000000, 16'h0,    1'b0, 17'h0,     32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'hFFFF, 1'b0, 17'h0,     32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'h1234, 1'b0, 17'h0,     32'h0},
      '{ROW_CSR, srds_pkg::REG_SEED, 32'h7FFFFFFF, 16'h0,    1'b0, 17'h0,     32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'hFFFF, 1'b0, 17'h0,     32'h0},
      '{ROW_REQ, srds_pkg::REG_MODE, 32'h0,        16'h0000, 1'b0, 17'h0,     32'h0}
   };

   scaled_random_dither_source i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] advance_seed(input logic mode, input logic [31:0] s);
      logic [31:0] sh;
      logic [31:0] t;
      if (mode == srds_pkg::MODE_XOR) begin
         sh = s << 13;
         t  = ((sh ^ s) >> 17) ^ sh ^ s;
         return (t << 5) ^ t;
      end
      return s * srds_pkg::LCG_MUL + srds_pkg::LCG_INC;
   endfunction

   // spread the seed to 52 bits, center it and scale it exactly
   function automatic logic [16:0] scale_dither(input logic [31:0] s, input logic [15:0] r);
      logic [51:0] spread;
      logic [51:0] mag;
      logic [67:0] prod;
      logic [16:0] q;
      logic        below;
      spread = {s, s[31:12]};
      below  = ~s[31];
      mag    = below ? srds_pkg::HALF_SCALE - spread : spread - srds_pkg::HALF_SCALE;
      prod   = mag * r;
      q      = prod[67:51] + {16'd0, prod[50]};
      return below ? -q : q;
   endfunction

   function automatic logic [15:0] pick_range();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(15));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_reg(input logic [srds_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      if (idx == srds_pkg::REG_MODE) begin
         model_mode = value[0];
      end else if (idx == srds_pkg::REG_SEED) begin
         model_seed = value;
      end
      @(posedge clock);
   endtask

   // leave req_tvalid high after the transaction; the caller drops it
   task automatic offer_range(input logic [15:0] r, input bit fixed,
                              input logic [16:0] fixed_dither, input logic [31:0] fixed_seed);
      dither_result_type want;
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      do @(posedge clock); while (!req_tready);
      model_seed  = advance_seed(model_mode, model_seed);
      want.seed   = model_seed;
      want.dither = scale_dither(model_seed, r);
      if (fixed) begin
         want.dither = fixed_dither;
         want.seed   = fixed_seed;
      end
      pending_dither.push_back(want);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_dither.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_sink
      dither_result_type want;
      logic              nxt_ready;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_dither.size() == 0) begin
            $display("%0t unexpected result: expected none actual %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_dither.pop_front();
            if (rsp_tdata[srds_pkg::DITHER_W-1:0] !== want.dither) begin
               $display("%0t dither_value mismatch: expected %h actual %h",
                        $time, want.dither, rsp_tdata[srds_pkg::DITHER_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[srds_pkg::DITHER_W+srds_pkg::SEED_W-1:srds_pkg::DITHER_W]
                !== want.seed) begin
               $display("%0t new_seed mismatch: expected %h actual %h",
                        $time, want.seed,
                        rsp_tdata[srds_pkg::DITHER_W+srds_pkg::SEED_W-1:srds_pkg::DITHER_W]);
               mismatch_count++;
            end
            if (rsp_tdata[srds_pkg::TDATA_OUT_W-1:srds_pkg::DITHER_W+srds_pkg::SEED_W]
                !== '0) begin
               $display("%0t padding mismatch: expected 0 actual %h", $time,
                        rsp_tdata[srds_pkg::TDATA_OUT_W-1:srds_pkg::DITHER_W+srds_pkg::SEED_W]);
               mismatch_count++;
            end
         end
      end
      if (hold_go && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         nxt_ready = 1'b0;
      end else begin
         nxt_ready = ($urandom_range(99) >= sink_stall_pct);
      end
      rsp_tready <= nxt_ready;
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int          pass_src [N_PASSES];
      int          pass_sink [N_PASSES];
      logic        pass_mode [N_PASSES];
      logic [31:0] pass_seed [N_PASSES];
      pass_src  = '{0, 52, 0, 29};
      pass_sink = '{0, 0, 52, 29};
      pass_mode = '{srds_pkg::MODE_XOR, srds_pkg::MODE_LCG, srds_pkg::MODE_LCG,
                    srds_pkg::MODE_XOR};
      pass_seed = '{$urandom, 32'hFFFFFFFF, 32'h00000000, 32'h80000000};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      model_mode = srds_pkg::MODE_LCG;
      model_seed = '0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain_results();
            write_reg(directed_rows[i].index, directed_rows[i].value);
         end else begin
            csr_wr_en <= 1'b0;
            offer_range(directed_rows[i].range, directed_rows[i].fixed,
                        directed_rows[i].dither, directed_rows[i].seed);
         end
      end

      for (int p = 0; p < N_PASSES; p++) begin
         drain_results();
         src_idle_pct   = pass_src[p];
         sink_stall_pct = pass_sink[p];
         write_reg(srds_pkg::REG_MODE, {31'($urandom), pass_mode[p]});
         write_reg(srds_pkg::REG_SEED, pass_seed[p]);
         csr_wr_en <= 1'b0;
         // stall the result side for a long stretch while requests keep coming
         if (p == 0) hold_go = 1'b1;
         for (int n = 0; n < ITEMS_PER_PASS; n++) begin
            offer_range(pick_range(), 1'b0, '0, '0);
         end
      end

      drain_results();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
